/* sv/dcrwp_pkg.sv */
// ----------------------------------------------------------------------------
// dcrwp_pkg
// Shared types and constants for the decimating capture ring with peak meter.
// ----------------------------------------------------------------------------
package dcrwp_pkg;

  // Store depth default
  localparam int RING_DEPTH_DEF = 65536;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 1'd1;
  localparam int CFG_DATA_W = 17;

  // Register reset values
  localparam logic [4:0]  RATIO_RESET  = 5'd4;
  localparam logic [16:0] WINLEN_RESET = 17'd49152;

  // Decimation ratio limits
  localparam logic [4:0] MAX_RATIO = 5'd16;
  localparam logic [4:0] MIN_RATIO = 5'd1;

  // Largest reported magnitude
  localparam logic [14:0] PEAK_LIMIT = 15'h7fff;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PEAK  = 2'd2
  } req_t;

  // Control of the peak accumulator
  typedef struct packed {
    logic clear;
    logic valid;
  } acc_ctl_t;

endpackage

/* sv/dcrwp_ring_ram.sv */
// ----------------------------------------------------------------------------
// dcrwp_ring_ram
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dcrwp_ring_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int W     = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/dcrwp_peak_acc.sv */
// ----------------------------------------------------------------------------
// dcrwp_peak_acc
// Running maximum of clamped sample magnitudes over a window walk.
// ----------------------------------------------------------------------------
module dcrwp_peak_acc
  import dcrwp_pkg::*;
(
  input  logic               clk,
  input  acc_ctl_t           ctl,
  input  logic signed [15:0] data,
  output logic [14:0]        peak
);

  logic [15:0] mag;
  logic [14:0] mag_clamped;

  // magnitude; full-scale negative clamps to the limit
  always_comb begin
    mag         = data[15] ? (16'd0 - data) : data;
    mag_clamped = mag[15] ? PEAK_LIMIT : mag[14:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      peak <= '0;
    end else if (ctl.valid && (mag_clamped > peak)) begin
      peak <= mag_clamped;
    end
  end

endmodule

/* sv/decimating_capture_ring_with_window_peak_core.sv */
// ----------------------------------------------------------------------------
// decimating_capture_ring_with_window_peak_core
// Decimating circular capture store with window read and window peak meter.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: sample_in, window_index
//          |     |                    | tuser: req_type, chunk_start
//  m_*     | out | m_tvalid/m_tready  | tdata: sample_out, peak, write_position,
//          |     |                    |   fill_count, windows_measured/skipped
//          |     |                    | tuser: ok, kept
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
//  Writes and refused requests are answered from the idle state, back to back.
//  A window read passes S_READ to wait for the registered store read data.
//  A peak request walks the window one store entry per cycle through the
//  single read port, then passes S_DRAIN and S_FIN; an empty window answers
//  directly from the idle state.
//  Reset is synchronous; the store is not cleared, no clearing pass.
//  s_tready is low while a result waits and m_tready is low.
// ----------------------------------------------------------------------------
module decimating_capture_ring_with_window_peak_core
  import dcrwp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,  // sample_in[15:0], window_index[31:16]
  input  logic [2:0]            s_tuser,  // req_type[1:0], chunk_start[2]
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [127:0]          m_tdata,  // sample_out[15:0], peak[30:16],
                                          // write_position[46:31],
                                          // fill_count[63:47],
                                          // windows_measured[95:64],
                                          // windows_skipped[127:96]
  output logic [1:0]            m_tuser,  // ok[0], kept[1]
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int CMPW = (CW > 17) ? CW : 17;
  localparam int WPW  = (AW > 16) ? AW : 16;
  localparam int SW   = WPW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state;

  // configuration and state registers
  logic [4:0]    ratio;
  logic [16:0]   wlen;
  logic [AW-1:0] wp;
  logic [CW-1:0] cnt;
  logic [3:0]    phase;
  logic [31:0]   meas;
  logic [31:0]   skip;

  // walk registers
  logic [AW-1:0] scan_addr;
  logic [16:0]   scan_left;
  logic          rvld;

  // result registers
  logic               out_vld;
  logic               o_ok;
  logic               o_kept;
  logic signed [15:0] o_smp;
  logic [14:0]        o_peak;

  // input fields
  req_t               in_req;
  logic               in_chunk;
  logic signed [15:0] in_smp;
  logic [15:0]        in_widx;
  logic               in_acc;

  always_comb begin
    in_req   = req_t'(s_tuser[1:0]);
    in_chunk = s_tuser[2];
    in_smp   = s_tdata[15:0];
    in_widx  = s_tdata[31:16];
  end

  assign s_tready = (state == S_IDLE) && (!out_vld || m_tready);
  assign in_acc   = s_tvalid && s_tready;

  // decimation phase
  logic [4:0] ratio_eff;
  logic [3:0] ph0;
  logic [3:0] ph1;
  logic [4:0] ph2;
  logic [3:0] phase_next;
  logic       keep;

  always_comb begin
    if (ratio < MIN_RATIO)      ratio_eff = MIN_RATIO;
    else if (ratio > MAX_RATIO) ratio_eff = MAX_RATIO;
    else                        ratio_eff = ratio;
    ph0        = in_chunk ? 4'd0 : phase;
    ph1        = ({1'b0, ph0} >= ratio_eff) ? 4'd0 : ph0;
    keep       = (ph1 == 4'd0);
    ph2        = {1'b0, ph1} + 5'd1;
    phase_next = (ph2 >= ratio_eff) ? 4'd0 : ph2[3:0];
  end

  // window placement; only used when the window is full, so wlen <= depth
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] wl_ext;
  logic            full;
  logic [AW-1:0]   wl_mod;
  logic [AW:0]     start_w;
  logic [AW-1:0]   start;
  logic [SW-1:0]   rd_sum;
  logic [SW-1:0]   rd_wrap;
  logic [AW-1:0]   rd_slot;
  logic            rd_ok;

  always_comb begin
    cnt_ext = CMPW'(cnt);
    wl_ext  = CMPW'(wlen);
    full    = (cnt_ext >= wl_ext);
    wl_mod  = (wl_ext == CMPW'(RING_DEPTH)) ? '0 : wl_ext[AW-1:0];
    if ({1'b0, wp} >= {1'b0, wl_mod}) begin
      start_w = {1'b0, wp} - {1'b0, wl_mod};
    end else begin
      start_w = {1'b0, wp} + (AW+1)'(RING_DEPTH) - {1'b0, wl_mod};
    end
    start   = start_w[AW-1:0];
    rd_sum  = SW'(start) + SW'(in_widx);
    rd_wrap = (rd_sum >= SW'(RING_DEPTH)) ? (rd_sum - SW'(RING_DEPTH)) : rd_sum;
    rd_slot = rd_wrap[AW-1:0];
    rd_ok   = full && (CMPW'(in_widx) < wl_ext);
  end

  // pointer steps
  logic [AW-1:0] wp_inc;
  logic [AW-1:0] scan_inc;

  assign wp_inc   = (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + AW'(1);
  assign scan_inc = (scan_addr == AW'(RING_DEPTH - 1)) ? '0 : scan_addr + AW'(1);

  // store
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [15:0] rd_data;

  assign wr_en   = in_acc && (in_req == REQ_WRITE) && keep;
  assign rd_en   = (in_acc && (in_req == REQ_READ) && rd_ok) || (state == S_SCAN);
  assign rd_addr = (state == S_SCAN) ? scan_addr : rd_slot;

  dcrwp_ring_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (AW),
    .W     (16)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp),
    .wr_data (in_smp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // peak accumulator
  acc_ctl_t    acc_ctl;
  logic [14:0] acc_peak;

  always_comb begin
    acc_ctl.clear = in_acc;
    acc_ctl.valid = rvld && ((state == S_SCAN) || (state == S_DRAIN));
  end

  dcrwp_peak_acc u_acc (
    .clk  (clk),
    .ctl  (acc_ctl),
    .data (rd_data),
    .peak (acc_peak)
  );

  // sequencer, state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
      rvld    <= 1'b0;
      ratio   <= RATIO_RESET;
      wlen    <= WINLEN_RESET;
      wp      <= '0;
      cnt     <= '0;
      phase   <= '0;
      meas    <= '0;
      skip    <= '0;
    end else begin
      rvld <= rd_en;

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_DECIM_RATIO: ratio <= cfg_data[4:0];
          REG_WINDOW_LEN:  wlen  <= cfg_data[16:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            o_ok   <= (in_req == REQ_PEAK) && full && (wlen == 17'd0);
            o_kept <= (in_req == REQ_WRITE) && keep;
            o_smp  <= '0;
            o_peak <= '0;
            case (in_req)
              REQ_WRITE: begin
                phase   <= phase_next;
                out_vld <= 1'b1;
                if (keep) begin
                  wp <= wp_inc;
                  if (cnt < CW'(RING_DEPTH)) begin
                    cnt <= cnt + CW'(1);
                  end
                end
              end
              REQ_READ: begin
                if (rd_ok) begin
                  out_vld <= 1'b0;
                  state   <= S_READ;
                end else begin
                  out_vld <= 1'b1;
                end
              end
              REQ_PEAK: begin
                if (full) begin
                  meas <= meas + 32'd1;
                  if (wlen == 17'd0) begin
                    out_vld <= 1'b1;
                  end else begin
                    out_vld   <= 1'b0;
                    scan_addr <= start;
                    scan_left <= wlen;
                    state     <= S_SCAN;
                  end
                end else begin
                  skip    <= skip + 32'd1;
                  out_vld <= 1'b1;
                end
              end
              default: begin
                out_vld <= 1'b1;
              end
            endcase
          end else if (m_tready) begin
            // pending result taken, nothing new
            out_vld <= 1'b0;
          end
        end
        S_READ: begin
          o_ok    <= 1'b1;
          o_smp   <= rd_data;
          out_vld <= 1'b1;
          state   <= S_IDLE;
        end
        S_SCAN: begin
          scan_addr <= scan_inc;
          scan_left <= scan_left - 17'd1;
          if (scan_left == 17'd1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          o_ok    <= 1'b1;
          o_peak  <= acc_peak;
          out_vld <= 1'b1;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result fields; the counters always reflect the latest item
  logic [WPW-1:0]  wp_ext;
  logic [CMPW-1:0] fill_ext;

  assign wp_ext   = WPW'(wp);
  assign fill_ext = CMPW'(cnt);

  assign m_tvalid = out_vld;
  assign m_tuser  = {o_kept, o_ok};
  assign m_tdata  = {skip, meas, fill_ext[16:0], wp_ext[15:0], o_peak, o_smp};

endmodule

/* sv/dcrwp_checker.sv */
// ----------------------------------------------------------------------------
// dcrwp_checker
// Port-level checks on the capture ring core, attached by bind.
// ----------------------------------------------------------------------------
module dcrwp_checker
  import dcrwp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [2:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [1:0]   m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // no new transaction while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input taken over a pending result");

  // a write answers in the next cycle, without ok
  a_write_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[1:0] == REQ_WRITE) |=> m_tvalid && !m_tuser[0])
    else $error("write result missing or flagged ok");

  // kept and ok never together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("kept and ok both set");

  // fill count saturates at the store depth
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (RING_DEPTH > 131071) || ({15'd0, m_tdata[63:47]} <= 32'(RING_DEPTH)))
    else $error("fill count beyond store depth");

endmodule

bind decimating_capture_ring_with_window_peak_core dcrwp_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_dcrwp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* dv/tb_decimating_capture_ring_with_window_peak_core.sv */
// ----------------------------------------------------------------------------
// tb_decimating_capture_ring_with_window_peak_core
// Self-checking bench for the decimating capture ring with window peak meter.
// A directed table covers reset values, extremes and corner cases. Random
// rounds with a fresh configuration follow. Each result is checked against
// table values or an in-bench predictor of the ring, decimator and peak walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_decimating_capture_ring_with_window_peak_core;
  import dcrwp_pkg::*;

  localparam int          DEPTH      = RING_DEPTH_DEF;
  localparam int          AW         = $clog2(DEPTH);
  localparam logic [1:0]  REQ_UNUSED = 2'd3;   // code with no function
  localparam int          IDLE_PCT   = 31;
  localparam int          QUIET_MAX  = 4000;   // cycles with no transaction
  localparam int          WIN_CAP    = 256;    // keeps peak walks short
  localparam int          ROUNDS     = 20;
  localparam int          ROUND_LEN  = 52;

  // One request and one result, at the widths of the ports
  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] smp;
    logic        chunk;
    logic [15:0] widx;
  } cap_req_t;

  typedef struct packed {
    logic        ok;
    logic        kept;
    logic [15:0] rd;
    logic [14:0] peak;
    logic [15:0] wpos;
    logic [16:0] fill;
    logic [31:0] meas;
    logic [31:0] skip;
  } cap_resp_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    cap_req_t                rq;
    logic                    typed;
    cap_resp_t               exp;
    logic [CFG_IDX_W-1:0]    cfg_idx;
    logic [CFG_DATA_W-1:0]   cfg_val;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata   = '0;  // sample_in[15:0], window_index[31:16]
  logic [2:0]            s_tuser   = '0;  // req_type[1:0], chunk_start[2]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [127:0]          m_tdata;         // sample_out, peak, write_position,
                                          // fill_count, measured, skipped
  logic [1:0]            m_tuser;         // ok[0], kept[1]
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  no_idle   = 1'b0;
  int                    err_cnt   = 0;
  int                    quiet_cnt = 0;
  cap_resp_t             expected_q[$];
  dir_row_t              dir_tbl[$];

  // Predictor state
  logic [15:0]           ring_mem[DEPTH];
  int unsigned           wr_ptr, fill_cnt, phase, ratio_reg, win_reg;
  logic [31:0]           meas_cnt, skip_cnt;

  always #1 clk = ~clk;

  decimating_capture_ring_with_window_peak_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Store slot of element i of the latest window
  function automatic int unsigned win_slot(int unsigned i);
    return (wr_ptr + DEPTH - (win_reg % DEPTH) + i) % DEPTH;
  endfunction

  // Next result of the capture ring; advances the predictor state
  function automatic cap_resp_t predict_capture(cap_req_t r);
    cap_resp_t   o;
    int unsigned ratio;
    int          v, mag, pk;
    o  = '0;
    pk = 0;
    case (r.req)
      REQ_WRITE: begin
        ratio = ratio_reg;
        if (ratio == 0) ratio = 1;
        if (ratio > MAX_RATIO) ratio = 32'(MAX_RATIO);
        if (r.chunk) phase = 0;
        if (phase >= ratio) phase = 0;
        if (phase == 0) begin
          ring_mem[AW'(wr_ptr)] = r.smp;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          if (fill_cnt < DEPTH) fill_cnt++;
          o.kept = 1'b1;
        end
        phase++;
        if (phase >= ratio) phase = 0;
      end
      REQ_READ: begin
        if (fill_cnt >= win_reg && r.widx < win_reg) begin
          o.rd = ring_mem[AW'(win_slot(32'(r.widx)))];
          o.ok = 1'b1;
        end
      end
      REQ_PEAK: begin
        if (fill_cnt >= win_reg) begin
          for (int unsigned i = 0; i < win_reg; i++) begin
            v   = int'($signed(ring_mem[AW'(win_slot(i))]));
            mag = (v < 0) ? -v : v;
            if (mag > pk) pk = mag;
          end
          if (pk > PEAK_LIMIT) pk = int'(PEAK_LIMIT);
          meas_cnt++;
          o.ok = 1'b1;
        end else begin
          skip_cnt++;
        end
      end
      default: ;
    endcase
    o.peak = pk[14:0];
    o.wpos = wr_ptr[15:0];
    o.fill = fill_cnt[16:0];
    o.meas = meas_cnt;
    o.skip = skip_cnt;
    return o;
  endfunction

  // Table rows
  function automatic dir_row_t item_row(logic [1:0] req, logic [15:0] smp,
                                        logic cs, logic [15:0] idx);
    dir_row_t row;
    row = '{kind: ROW_ITEM, rq: '{req, smp, cs, idx}, typed: 1'b0, exp: '0,
            cfg_idx: '0, cfg_val: '0};
    return row;
  endfunction

  // Refusals and first writes after reset: ok, sample, peak and measured are 0
  function automatic dir_row_t checked_row(logic [1:0] req, logic [15:0] smp,
                                           logic cs, logic [15:0] idx,
                                           logic kept, logic [15:0] wpos,
                                           logic [16:0] fill, logic [31:0] skip);
    dir_row_t row;
    row          = item_row(req, smp, cs, idx);
    row.typed    = 1'b1;
    row.exp      = '0;
    row.exp.kept = kept;
    row.exp.wpos = wpos;
    row.exp.fill = fill;
    row.exp.skip = skip;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{kind: ROW_CFG, rq: '0, typed: 1'b0, exp: '0,
            cfg_idx: idx, cfg_val: val};
    return row;
  endfunction

  // Drive one request, wait for its transaction, queue its expected result
  task automatic send_req(cap_req_t r, logic typed, cap_resp_t typed_exp);
    cap_resp_t p;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.widx, r.smp};
    s_tuser  <= {r.chunk, r.req};
    do @(posedge clk); while (!s_tready);
    p = predict_capture(r);
    expected_q.push_back(typed ? typed_exp : p);
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_DECIM_RATIO) ratio_reg = 32'(val[4:0]);
    else win_reg = 32'(val);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < 40)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Result side: random back-pressure and field-by-field check
  always @(posedge clk) begin
    cap_resp_t got, want;
    m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    if (!rst && m_tvalid && m_tready) begin
      got.ok   = m_tuser[0];
      got.kept = m_tuser[1];
      got.rd   = m_tdata[15:0];
      got.peak = m_tdata[30:16];
      got.wpos = m_tdata[46:31];
      got.fill = m_tdata[63:47];
      got.meas = m_tdata[95:64];
      got.skip = m_tdata[127:96];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = expected_q.pop_front();
        if (got.ok !== want.ok)
          report_mismatch("ok", 32'(got.ok), 32'(want.ok));
        if (got.kept !== want.kept)
          report_mismatch("kept", 32'(got.kept), 32'(want.kept));
        if (got.rd !== want.rd)
          report_mismatch("sample_out", 32'(got.rd), 32'(want.rd));
        if (got.peak !== want.peak)
          report_mismatch("peak", 32'(got.peak), 32'(want.peak));
        if (got.wpos !== want.wpos)
          report_mismatch("write_position", 32'(got.wpos), 32'(want.wpos));
        if (got.fill !== want.fill)
          report_mismatch("fill_count", 32'(got.fill), 32'(want.fill));
        if (got.meas !== want.meas) report_mismatch("measured", got.meas, want.meas);
        if (got.skip !== want.skip) report_mismatch("skipped", got.skip, want.skip);
      end
    end
  end

  // Watchdog: too long without any transaction on either stream
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= QUIET_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus
  initial begin
    cap_req_t    r;
    int unsigned sel, cap, idx_top;
    logic [CFG_DATA_W-1:0] wl;

    wr_ptr    = 0;
    fill_cnt  = 0;
    phase     = 0;
    meas_cnt  = '0;
    skip_cnt  = '0;
    ratio_reg = 32'(RATIO_RESET);
    win_reg   = 32'(WINLEN_RESET);

    // Reset-state refusals, code 3, extremes and chunk restart
    dir_tbl.push_back(checked_row(REQ_READ,   16'h0000, 1'b0, 16'h0000,
                                  1'b0, 16'd0, 17'd0, 32'd0));
    dir_tbl.push_back(checked_row(REQ_PEAK,   16'h0000, 1'b0, 16'h0000,
                                  1'b0, 16'd0, 17'd0, 32'd1));
    dir_tbl.push_back(checked_row(REQ_UNUSED, 16'h5a5a, 1'b1, 16'hffff,
                                  1'b0, 16'd0, 17'd0, 32'd1));
    dir_tbl.push_back(checked_row(REQ_WRITE,  16'h7fff, 1'b1, 16'h0000,
                                  1'b1, 16'd1, 17'd1, 32'd1));
    dir_tbl.push_back(checked_row(REQ_WRITE,  16'h8000, 1'b0, 16'h0000,
                                  1'b0, 16'd1, 17'd1, 32'd1));
    dir_tbl.push_back(item_row(REQ_WRITE, 16'hffff, 1'b1, 16'h0000));
    // Ratio zero acts as one; empty window always measures
    dir_tbl.push_back(cfg_row(REG_DECIM_RATIO, 17'd0));
    dir_tbl.push_back(cfg_row(REG_WINDOW_LEN, 17'd0));
    dir_tbl.push_back(item_row(REQ_PEAK,  16'h0000, 1'b0, 16'h0000));
    dir_tbl.push_back(item_row(REQ_READ,  16'h0000, 1'b0, 16'h0000));
    dir_tbl.push_back(item_row(REQ_WRITE, 16'h8000, 1'b0, 16'h0000));
    dir_tbl.push_back(item_row(REQ_WRITE, 16'd100,  1'b0, 16'h0000));
    // Two-sample window: clamp of the most negative sample, index bounds
    dir_tbl.push_back(cfg_row(REG_WINDOW_LEN, 17'd2));
    dir_tbl.push_back(item_row(REQ_PEAK, 16'h0000, 1'b0, 16'h0000));
    dir_tbl.push_back(item_row(REQ_READ, 16'h0000, 1'b0, 16'd0));
    dir_tbl.push_back(item_row(REQ_READ, 16'h0000, 1'b0, 16'd1));
    dir_tbl.push_back(item_row(REQ_READ, 16'h0000, 1'b0, 16'd2));
    dir_tbl.push_back(item_row(REQ_READ, 16'h0000, 1'b0, 16'hffff));
    // Ratio above sixteen saturates
    dir_tbl.push_back(cfg_row(REG_DECIM_RATIO, 17'd31));
    dir_tbl.push_back(cfg_row(REG_WINDOW_LEN, 17'd3));
    dir_tbl.push_back(item_row(REQ_WRITE, 16'd5, 1'b1, 16'h0000));
    dir_tbl.push_back(item_row(REQ_WRITE, 16'd6, 1'b0, 16'h0000));
    dir_tbl.push_back(item_row(REQ_PEAK,  16'h0000, 1'b0, 16'h0000));
    // Windows longer than the store can never fill; a store-length window is not yet full
    dir_tbl.push_back(cfg_row(REG_DECIM_RATIO, 17'd16));
    dir_tbl.push_back(cfg_row(REG_WINDOW_LEN, 17'h1ffff));
    dir_tbl.push_back(item_row(REQ_PEAK, 16'h0000, 1'b0, 16'h0000));
    dir_tbl.push_back(item_row(REQ_READ, 16'h0000, 1'b0, 16'h0000));
    dir_tbl.push_back(cfg_row(REG_DECIM_RATIO, 17'd17));
    dir_tbl.push_back(cfg_row(REG_WINDOW_LEN, 17'd65536));
    dir_tbl.push_back(item_row(REQ_PEAK,  16'h0000, 1'b0, 16'h0000));
    dir_tbl.push_back(item_row(REQ_WRITE, 16'hfff9, 1'b1, 16'h0000));
    dir_tbl.push_back(item_row(REQ_READ,  16'h0000, 1'b0, 16'hffff));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_tbl[i].cfg_idx, dir_tbl[i].cfg_val);
      end else begin
        send_req(dir_tbl[i].rq, dir_tbl[i].typed, dir_tbl[i].exp);
      end
    end

    // Random rounds, each with a new setting written while idle
    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      drain_results();
      no_idle <= (rnd >= 6 && rnd < 9);

      sel = $urandom_range(0, 9);
      if (sel < 6)       wl = CFG_DATA_W'($urandom_range(1, 4));
      else if (sel == 6) wl = '0;
      else if (sel == 7) wl = CFG_DATA_W'(16);
      else if (sel == 8) wl = CFG_DATA_W'($urandom_range(17, 31));
      else               wl = CFG_DATA_W'($urandom_range(5, 15));
      write_reg(REG_DECIM_RATIO, wl);

      // Mostly windows the ring can already satisfy
      cap = (fill_cnt < WIN_CAP) ? fill_cnt : WIN_CAP;
      sel = $urandom_range(0, 19);
      if (sel == 0)
        wl = '0;
      else if (sel == 1)
        wl = CFG_DATA_W'($urandom_range(65536, 131071));
      else if (sel < 5 && fill_cnt < WIN_CAP)
        wl = CFG_DATA_W'(fill_cnt + $urandom_range(1, 8));
      else if (cap == 0)
        wl = CFG_DATA_W'(1);
      else
        wl = CFG_DATA_W'($urandom_range(1, cap));
      write_reg(REG_WINDOW_LEN, wl);

      for (int n = 0; n < ROUND_LEN; n++) begin
        sel      = $urandom_range(0, 99);
        r.smp    = 16'($urandom);
        r.widx   = 16'($urandom);
        r.chunk  = 1'($urandom_range(0, 1));
        if (sel < 60) begin
          r.req   = REQ_WRITE;
          r.chunk = ($urandom_range(0, 9) == 0);
          case ($urandom_range(0, 19))
            0: r.smp = 16'h7fff;
            1: r.smp = 16'h8000;
            2: r.smp = 16'hffff;
            3: r.smp = 16'h0000;
            default: ;
          endcase
        end else if (sel < 82) begin
          r.req   = REQ_READ;
          idx_top = (win_reg > 65535) ? 65535 : win_reg;
          if ($urandom_range(0, 4) != 0) r.widx = 16'($urandom_range(0, idx_top));
        end else if (sel < 95) begin
          r.req = REQ_PEAK;
        end else begin
          r.req = REQ_UNUSED;
        end
        send_req(r, 1'b0, '0);
      end
    end

    // Let everything come back, then watch for stray results
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
